FILE: hdl/fbpm_pkg.sv
// Shared types and constants of the fixed block pool manager.
// Holds the result status codes, the request kinds and the register indexes.
// Depends on nothing.
`timescale 1ns / 1ps

package fbpm_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_SIZE     = 3'd2,
		ST_ALIGN    = 3'd3,
		ST_INDEX    = 3'd4,
		ST_NONE_OUT = 3'd5
	} status_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		REG_BLOCK_BYTES = 2'd0,
		REG_BLOCKS      = 2'd1,
		REG_ALIGNMENT   = 2'd2,
		REG_BASE        = 2'd3
	} reg_index_t;

	localparam int HEAD_W   = 9;
	localparam int BYTES_W  = 13;
	localparam int ACTIVE_W = 21;
	localparam int PROD_W   = HEAD_W + BYTES_W;

	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd64;
	localparam logic [BYTES_W-1:0] ALIGNMENT_RESET   = 13'd16;
	localparam logic [HEAD_W-1:0]  BLOCKS_RESET      = 9'd256;

endpackage

FILE: hdl/fixed_block_pool_manager_top.sv
// Top level of the fixed block pool manager: free list, statistics and result register.
// Depends on fbpm_pkg for status codes, request kinds and register indexes.
`timescale 1ns / 1ps

// The block hands out equal-size blocks from a last-in-first-out free list and takes
// them back. Each request is one transfer on the req channel and yields exactly one
// transfer on the rsp channel, in order. The next request is taken only once the one
// before it has updated the head: the head's link is read from a synchronous link
// memory in the cycle the request is accepted, and the head is updated from that data
// when the request moves to stage 2, after which the next request may enter. The result
// goes through stage 2 to an output register and waits there while rsp_stall is high.
// Blocks that were never handed out form an implicit ascending chain behind fresh_q,
// so the link memory needs no clearing pass after reset: only freed blocks write it.
// Rejected requests change no state. Writing the block count restarts the free list
// and keeps the statistics. Configuration writes are only legal while no request is
// in flight.
module fixed_block_pool_manager_top #(
	parameter int NUM_BLOCKS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [31:0]                     cfg_data,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            kind,
	input  logic [15:0]                     request_size,
	input  logic [15:0]                     request_alignment,
	input  logic [7:0]                      block_index,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [2:0]                      status,
	output logic [7:0]                      granted_index,
	output logic [31:0]                     granted_address,
	output logic [8:0]                      blocks_free,
	output logic [20:0]                     active_bytes,
	output logic [20:0]                     peak_bytes,
	output logic [31:0]                     allocs_total,
	output logic [31:0]                     frees_total
);

	import fbpm_pkg::*;

	// The link memory only ever holds entries for blocks a free can name.
	localparam int LINK_DEPTH = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
	localparam int LINK_AW    = $clog2(LINK_DEPTH);
	// Largest usable count: the register is nine bits wide.
	localparam int CNT_MAX_I  = (NUM_BLOCKS < 511) ? NUM_BLOCKS : 511;
	localparam logic [HEAD_W-1:0] CNT_MAX   = HEAD_W'(CNT_MAX_I);
	localparam logic [HEAD_W-1:0] CNT_RESET = (BLOCKS_RESET > CNT_MAX) ? CNT_MAX : BLOCKS_RESET;
	localparam logic [ACTIVE_W-1:0] ACTIVE_SAT = '1;

	// Configuration registers.
	logic [BYTES_W-1:0] block_bytes_q;
	logic [BYTES_W-1:0] alignment_q;
	logic [31:0]        base_q;
	logic [HEAD_W-1:0]  cnt_q;
	logic [HEAD_W-1:0]  cfg_cnt;

	// Free list and statistics.
	logic [HEAD_W-1:0]   head_q;
	logic [HEAD_W-1:0]   fresh_q;
	logic [HEAD_W-1:0]   free_q;
	logic [ACTIVE_W-1:0] peak_q;
	logic [31:0]         allocs_q;
	logic [31:0]         frees_q;

	// Link memory: one write port for frees, one registered read of the head.
	logic [HEAD_W-1:0] link_mem [LINK_DEPTH];
	logic [HEAD_W-1:0] link_rd_q;
	logic              link_we;

	// Stage 1: the accepted request, while the link read completes.
	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] size_s1;
	logic [15:0] align_s1;
	logic [7:0]  idx_s1;

	// Stage 2: the decision and the state after the request.
	logic              valid_s2;
	status_t           status_s2;
	logic              grant_s2;
	logic [HEAD_W-1:0] grant_idx_s2;
	logic [HEAD_W-1:0] used_s2;
	logic [HEAD_W-1:0] free_s2;
	logic [31:0]       allocs_s2;
	logic [31:0]       frees_s2;

	// Result register.
	logic                rsp_valid_q;
	status_t             status_q;
	logic [7:0]          granted_index_q;
	logic [31:0]         granted_address_q;
	logic [HEAD_W-1:0]   blocks_free_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [ACTIVE_W-1:0] peak_out_q;
	logic [31:0]         allocs_out_q;
	logic [31:0]         frees_out_q;

	logic req_take;
	logic adv_s1;
	logic adv_s2;

	// One request is in flight ahead of the head update; the next one waits for it.
	assign req_stall = valid_s1;
	assign req_take  = req_valid && !req_stall;
	assign adv_s2    = valid_s2 && (!rsp_valid_q || !rsp_stall);
	assign adv_s1    = valid_s1 && (!valid_s2 || adv_s2);

	assign cfg_cnt = (cfg_data[HEAD_W-1:0] > CNT_MAX) ? CNT_MAX : cfg_data[HEAD_W-1:0];

	// Decision for the request in stage 1.
	status_t           dec_status;
	logic              dec_grant;
	logic [HEAD_W-1:0] head_n;
	logic [HEAD_W-1:0] fresh_n;
	logic [HEAD_W-1:0] free_n;
	logic [31:0]       allocs_n;
	logic [31:0]       frees_n;

	always_comb begin
		dec_status = ST_OK;
		dec_grant  = 1'b0;
		link_we    = 1'b0;
		head_n     = head_q;
		fresh_n    = fresh_q;
		free_n     = free_q;
		allocs_n   = allocs_q;
		frees_n    = frees_q;
		if (kind_s1 == KIND_ALLOC) begin
			if (size_s1 > {3'd0, block_bytes_q}) begin
				dec_status = ST_SIZE;
			end else if (align_s1 > {3'd0, alignment_q}) begin
				dec_status = ST_ALIGN;
			end else if (free_q == '0 || head_q >= cnt_q) begin
				dec_status = ST_EMPTY;
			end else begin
				dec_grant = 1'b1;
				// Popping the front of the untouched chain needs no link.
				if (head_q == fresh_q) begin
					head_n  = head_q + HEAD_W'(1);
					fresh_n = head_q + HEAD_W'(1);
				end else begin
					head_n = link_rd_q;
				end
				free_n   = free_q - HEAD_W'(1);
				allocs_n = allocs_q + 32'd1;
			end
		end else begin
			if ({1'b0, idx_s1} >= cnt_q) begin
				dec_status = ST_INDEX;
			end else if (free_q >= cnt_q) begin
				dec_status = ST_NONE_OUT;
			end else begin
				link_we = valid_s1 && adv_s1;
				head_n  = {1'b0, idx_s1};
				free_n  = free_q + HEAD_W'(1);
				frees_n = frees_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			link_rd_q <= link_mem[head_q[LINK_AW-1:0]];
		end
		if (link_we) begin
			link_mem[idx_s1[LINK_AW-1:0]] <= head_q;
		end
	end

	// Configuration and free list state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RESET;
			alignment_q   <= ALIGNMENT_RESET;
			base_q        <= '0;
			cnt_q         <= CNT_RESET;
			head_q        <= '0;
			fresh_q       <= '0;
			free_q        <= CNT_RESET;
			allocs_q      <= '0;
			frees_q       <= '0;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[BYTES_W-1:0];
				REG_BLOCKS: begin
					cnt_q   <= cfg_cnt;
					head_q  <= '0;
					fresh_q <= '0;
					free_q  <= cfg_cnt;
				end
				REG_ALIGNMENT: alignment_q <= cfg_data[BYTES_W-1:0];
				REG_BASE: base_q <= cfg_data;
				default: ;
			endcase
		end else if (adv_s1) begin
			head_q   <= head_n;
			fresh_q  <= fresh_n;
			free_q   <= free_n;
			allocs_q <= allocs_n;
			frees_q  <= frees_n;
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload of stages 1 and 2.
	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_s1  <= kind;
			size_s1  <= request_size;
			align_s1 <= request_alignment;
			idx_s1   <= block_index;
		end
		if (adv_s1) begin
			status_s2    <= dec_status;
			grant_s2     <= dec_grant;
			grant_idx_s2 <= head_q;
			used_s2      <= cnt_q - free_n;
			free_s2      <= free_n;
			allocs_s2    <= allocs_n;
			frees_s2     <= frees_n;
		end
	end

	// Stage 3: address and active bytes, one small multiplier each.
	logic [PROD_W-1:0]   addr_prod;
	logic [PROD_W-1:0]   act_prod;
	logic [ACTIVE_W-1:0] act_sat;
	logic [ACTIVE_W-1:0] peak_n;

	assign addr_prod = {{BYTES_W{1'b0}}, grant_idx_s2} * {{HEAD_W{1'b0}}, block_bytes_q};
	assign act_prod  = {{BYTES_W{1'b0}}, used_s2} * {{HEAD_W{1'b0}}, block_bytes_q};
	assign act_sat   = (act_prod > PROD_W'(ACTIVE_SAT)) ? ACTIVE_SAT : act_prod[ACTIVE_W-1:0];
	assign peak_n    = (grant_s2 && act_sat > peak_q) ? act_sat : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (adv_s2) begin
			peak_q <= peak_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			status_q          <= status_s2;
			granted_index_q   <= grant_s2 ? grant_idx_s2[7:0] : 8'd0;
			granted_address_q <= grant_s2 ? base_q + 32'(addr_prod) : 32'd0;
			blocks_free_q     <= free_s2;
			active_q          <= act_sat;
			peak_out_q        <= peak_n;
			allocs_out_q      <= allocs_s2;
			frees_out_q       <= frees_s2;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign granted_index   = granted_index_q;
	assign granted_address = granted_address_q;
	assign blocks_free     = blocks_free_q;
	assign active_bytes    = active_q;
	assign peak_bytes      = peak_out_q;
	assign allocs_total    = allocs_out_q;
	assign frees_total     = frees_out_q;

`ifndef SYNTHESIS
	a_free_within_pool: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= cnt_q)
		else $error("free block count exceeds the pool size");

	a_fresh_within_pool: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= cnt_q)
		else $error("untouched chain front runs past the pool");

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> valid_s1)
		else $error("accepted request did not enter stage 1");

	a_reject_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (granted_index == 8'd0 && granted_address == 32'd0))
		else $error("rejected request carries a grant");

	a_peak_covers_active: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && grant_s2) |=> (peak_q >= active_q))
		else $error("peak bytes below active bytes after an allocate");
`endif

endmodule

FILE: dv/fixed_block_pool_manager_top_tb.sv
// Self-checking testbench for the fixed block pool manager top level.
// Depends on fbpm_pkg and fixed_block_pool_manager_top; the expected result of every
// request comes from a predictor of the free list kept inside this file.
`timescale 1ns / 1ps

module fixed_block_pool_manager_top_tb;

	import fbpm_pkg::*;

	localparam int NUM_BLOCKS   = 256;
	// Cycles without any transfer before the run is declared hung. The longest honest
	// gap is the deliberate output hold-off.
	localparam int IDLE_LIMIT   = 5000;
	// Cycles to wait at the end after the last result has been checked.
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		status_t     status;
		logic [7:0]  granted_index;
		logic [31:0] granted_address;
		logic [8:0]  blocks_free;
		logic [20:0] active_bytes;
		logic [20:0] peak_bytes;
		logic [31:0] allocs_total;
		logic [31:0] frees_total;
	} pool_result_t;

	logic        clk;
	logic        arst_n            = 1'b0;
	logic        cfg_write         = 1'b0;
	logic [1:0]  cfg_index         = '0;
	logic [31:0] cfg_data          = '0;
	logic        req_valid         = 1'b0;
	logic        req_stall;
	logic        kind              = KIND_ALLOC;
	logic [15:0] request_size      = '0;
	logic [15:0] request_alignment = '0;
	logic [7:0]  block_index       = '0;
	logic        rsp_valid;
	logic        rsp_stall         = 1'b0;
	logic [2:0]  status;
	logic [7:0]  granted_index;
	logic [31:0] granted_address;
	logic [8:0]  blocks_free;
	logic [20:0] active_bytes;
	logic [20:0] peak_bytes;
	logic [31:0] allocs_total;
	logic [31:0] frees_total;

	fixed_block_pool_manager_top #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.kind             (kind),
		.request_size     (request_size),
		.request_alignment(request_alignment),
		.block_index      (block_index),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.status           (status),
		.granted_index    (granted_index),
		.granted_address  (granted_address),
		.blocks_free      (blocks_free),
		.active_bytes     (active_bytes),
		.peak_bytes       (peak_bytes),
		.allocs_total     (allocs_total),
		.frees_total      (frees_total)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Predicted pool state and register copies. Links are kept nine bits wide because
	// the end-of-list mark (the block count itself) can be pushed as a link.
	logic [8:0]   link_mem [NUM_BLOCKS];
	logic [8:0]   model_head;
	logic [8:0]   model_fresh;
	logic [8:0]   model_free;
	logic [20:0]  model_peak;
	logic [31:0]  model_allocs;
	logic [31:0]  model_frees;
	logic [12:0]  set_block_bytes;
	logic [8:0]   set_blocks;
	logic [12:0]  set_alignment;
	logic [31:0]  set_base;

	// Blocks handed out and not yet returned, used to build well-formed frees.
	logic [7:0]   held_blocks [$];
	pool_result_t pending_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;

	// The long output hold-off is requested by flipping hold_toggle; the receiver
	// process notices the flip and counts the stretch down on its own.
	logic hold_toggle = 1'b0;
	logic hold_seen   = 1'b0;
	int   hold_len    = 0;
	int   hold_left   = 0;

	function automatic logic [8:0] pool_size();
		return (set_blocks > NUM_BLOCKS) ? 9'(NUM_BLOCKS) : set_blocks;
	endfunction

	function automatic logic [20:0] active_amount();
		logic [8:0]  cnt;
		logic [63:0] bytes;
		cnt = pool_size();
		bytes = (cnt > model_free) ? 64'(cnt - model_free) * 64'(set_block_bytes) : 64'd0;
		return (bytes > 64'h1F_FFFF) ? 21'h1F_FFFF : bytes[20:0];
	endfunction

	function automatic void restart_free_list();
		model_head  = '0;
		model_fresh = '0;
		model_free  = pool_size();
		held_blocks.delete();
	endfunction

	function automatic void reset_model();
		set_block_bytes = BLOCK_BYTES_RESET;
		set_blocks      = BLOCKS_RESET;
		set_alignment   = ALIGNMENT_RESET;
		set_base        = '0;
		restart_free_list();
		model_peak   = '0;
		model_allocs = '0;
		model_frees  = '0;
	endfunction

	// Applies one accepted request to the predicted pool and returns its result.
	function automatic pool_result_t apply_request(input logic k, input logic [15:0] sz,
			input logic [15:0] al, input logic [7:0] idx);
		pool_result_t r;
		logic [8:0]   cnt;
		logic [8:0]   h;
		logic [20:0]  act;
		bit           found;
		cnt = pool_size();
		r = '0;
		r.status = ST_OK;
		if (k == KIND_ALLOC) begin
			if (sz > 16'(set_block_bytes)) begin
				r.status = ST_SIZE;
			end else if (al > 16'(set_alignment)) begin
				r.status = ST_ALIGN;
			end else if (model_free == 0 || model_head >= cnt) begin
				r.status = ST_EMPTY;
			end else begin
				h = model_head;
				// Untouched blocks follow each other in ascending order.
				if (h == model_fresh) begin
					model_head  = h + 9'd1;
					model_fresh = h + 9'd1;
				end else begin
					model_head = link_mem[h[7:0]];
				end
				model_free   = model_free - 9'd1;
				model_allocs = model_allocs + 32'd1;
				act = active_amount();
				if (act > model_peak) begin
					model_peak = act;
				end
				r.granted_index   = h[7:0];
				r.granted_address = set_base + 32'(h) * 32'(set_block_bytes);
				held_blocks.push_back(h[7:0]);
			end
		end else begin
			if (9'(idx) >= cnt) begin
				r.status = ST_INDEX;
			end else if (model_free >= cnt) begin
				r.status = ST_NONE_OUT;
			end else begin
				link_mem[idx] = model_head;
				model_head    = 9'(idx);
				model_free    = model_free + 9'd1;
				model_frees   = model_frees + 32'd1;
				found = 1'b0;
				for (int j = 0; j < held_blocks.size() && !found; j++) begin
					if (held_blocks[j] == idx) begin
						held_blocks.delete(j);
						found = 1'b1;
					end
				end
			end
		end
		r.blocks_free  = model_free;
		r.active_bytes = active_amount();
		r.peak_bytes   = model_peak;
		r.allocs_total = model_allocs;
		r.frees_total  = model_frees;
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", field, want, got);
			mismatches++;
		end
	endtask

	// Result side: checks every transfer against the oldest prediction, then decides
	// the stall for the next cycle.
	always @(posedge clk) begin : result_check
		pool_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("granted_index", 32'(want.granted_index), 32'(granted_index));
				compare_field("granted_address", want.granted_address, granted_address);
				compare_field("blocks_free", 32'(want.blocks_free), 32'(blocks_free));
				compare_field("active_bytes", 32'(want.active_bytes), 32'(active_bytes));
				compare_field("peak_bytes", 32'(want.peak_bytes), 32'(peak_bytes));
				compare_field("allocs_total", want.allocs_total, allocs_total);
				compare_field("frees_total", want.frees_total, frees_total);
			end
		end
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= hold_len;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: ends a run in which no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offers one request, possibly after idle cycles, and records its prediction once
	// the transfer happens. Valid stays high on return so requests can go back to back.
	task automatic send_request(input logic k, input logic [15:0] sz, input logic [15:0] al,
			input logic [7:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid         <= 1'b1;
		kind              <= k;
		request_size      <= sz;
		request_alignment <= al;
		block_index       <= idx;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		pending_results.push_back(apply_request(k, sz, al, idx));
	endtask

	// Stops offering and waits until every predicted result has been checked, so the
	// block is idle and registers may be written.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BLOCK_BYTES: set_block_bytes = value[12:0];
			REG_BLOCKS: begin
				set_blocks = value[8:0];
				restart_free_list();
			end
			REG_ALIGNMENT: set_alignment = value[12:0];
			REG_BASE: set_base = value;
			default: ;
		endcase
	endtask

	task automatic set_pool_config(input int bytes, input int blocks, input int align,
			input logic [31:0] base);
		write_reg(REG_BLOCK_BYTES, 32'(bytes));
		write_reg(REG_BLOCKS, 32'(blocks));
		write_reg(REG_ALIGNMENT, 32'(align));
		write_reg(REG_BASE, base);
	endtask

	// Mostly well-formed traffic: allocations that fit and frees of blocks that are
	// held. About one request in seven is noise with arbitrary fields.
	task automatic run_random_phase(input int count, input int alloc_weight);
		int          roll;
		logic        k;
		logic [15:0] sz;
		logic [15:0] al;
		logic [7:0]  idx;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			sz   = 16'($urandom);
			al   = 16'($urandom);
			idx  = 8'($urandom);
			if (roll < 15) begin
				k = 1'($urandom_range(1));
				if ($urandom_range(1) == 0) begin
					sz = 16'($urandom_range(32'(set_block_bytes) + 1));
				end
				if ($urandom_range(1) == 0) begin
					al = 16'($urandom_range(32'(set_alignment) + 1));
				end
			end else if (held_blocks.size() != 0 && $urandom_range(99) >= alloc_weight) begin
				k   = KIND_FREE;
				idx = held_blocks[$urandom_range(held_blocks.size() - 1)];
			end else begin
				k  = KIND_ALLOC;
				sz = 16'($urandom_range(32'(set_block_bytes)));
				al = 16'($urandom_range(32'(set_alignment)));
			end
			send_request(k, sz, al, idx);
		end
	endtask

	// Reset values: nothing outstanding, a fitting allocate, and the size and
	// alignment rejections including the all-ones request.
	task automatic test_reset_values();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd0);
		send_request(KIND_ALLOC, 16'd64, 16'd16, 8'd0);
		send_request(KIND_ALLOC, 16'd65, 16'd0, 8'd0);
		send_request(KIND_ALLOC, 16'd0, 16'd17, 8'd0);
		send_request(KIND_ALLOC, 16'hFFFF, 16'hFFFF, 8'hFF);
		drain_results();
	endtask

	// Tiny pools with the largest blocks and an address that wraps: empty pool, index
	// out of range, double free, freeing the block at the fresh front, freeing a block
	// never handed out, and a head at the end mark while a block still counts as free.
	task automatic test_edge_cases();
		set_pool_config(4096, 2, 4096, 32'hFFFF_F800);
		send_request(KIND_ALLOC, 16'd4096, 16'd4096, 8'd0);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		send_request(KIND_ALLOC, 16'd1, 16'd1, 8'd0);
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd2);
		send_request(KIND_FREE, 16'hFFFF, 16'hFFFF, 8'd255);
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd1);
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd1);
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd0);
		send_request(KIND_ALLOC, 16'd7, 16'd3, 8'd0);
		send_request(KIND_ALLOC, 16'd7, 16'd3, 8'd0);
		drain_results();
		write_reg(REG_BLOCKS, 32'd2);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd1);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		drain_results();
		write_reg(REG_BLOCKS, 32'd4);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		send_request(KIND_FREE, 16'd0, 16'd0, 8'd3);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		send_request(KIND_ALLOC, 16'd0, 16'd0, 8'd0);
		drain_results();
	endtask

	task automatic test_steady_stream();
		set_pool_config(64, 256, 16, 32'h1000_0000);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_phase(150, 70);
		drain_results();
	endtask

	// The smallest settings of every register and a base of all ones.
	task automatic test_single_block();
		set_pool_config(1, 1, 1, 32'hFFFF_FFFF);
		send_idle_pct  = 68;
		recv_stall_pct = 0;
		run_random_phase(80, 50);
		drain_results();
	endtask

	// Largest blocks, biased toward allocation so active and peak bytes climb high.
	task automatic test_large_blocks();
		set_pool_config(4096, 256, 4096, 32'hFFF0_0000);
		send_idle_pct  = 0;
		recv_stall_pct = 68;
		run_random_phase(200, 80);
		drain_results();
	endtask

	task automatic test_random_configs();
		send_idle_pct  = 6;
		recv_stall_pct = 6;
		for (int p = 0; p < 3; p++) begin
			set_pool_config($urandom_range(4096, 1), $urandom_range(16, 1),
				$urandom_range(4096, 1), $urandom);
			run_random_phase(40, 60);
			drain_results();
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the
	// block fills up and stalls its request side.
	task automatic test_output_backpressure();
		set_pool_config(16, 8, 8, 32'h0000_4000);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len    <= HOLD_CYCLES;
		hold_toggle <= ~hold_toggle;
		run_random_phase(60, 55);
		drain_results();
	endtask

	initial begin
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_edge_cases();
		test_steady_stream();
		test_single_block();
		test_large_blocks();
		test_random_configs();
		test_output_backpressure();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
